### sv/flp_pkg.sv
// Shared types and constants for the free-list slot pool.
package flp_pkg;

  // Field widths of the stream items
  localparam int MODE_W    = 2;
  localparam int IDX_W     = 7;
  localparam int IVAL_W    = 32;
  localparam int GIDX_W    = 6;
  localparam int RVAL_W    = 32;

  // Packed stream widths
  localparam int S_TUSER_W = MODE_W;
  localparam int S_TDATA_W = 40;  // slot_index + item_value, padded to bytes
  localparam int M_TDATA_W = 48;  // ok, given_index, in_use, read_value, pool_full

  // Bit positions in the result tdata
  localparam int OUT_OK_LSB    = 0;
  localparam int OUT_GIDX_LSB  = 1;
  localparam int OUT_USED_LSB  = 7;
  localparam int OUT_RVAL_LSB  = 8;
  localparam int OUT_FULL_LSB  = 40;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Sequencer strobes towards the datapath
  typedef struct packed {
    logic accept;  // item taken, memory lookup issued
    logic fire;    // write-back and result load this cycle
  } flp_ctrl_t;

endpackage

### sv/flp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module flp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no new read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/flp_seq.sv
// Two-state sequencer: lookup on accept, then write-back once the result slot is free.
module flp_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  output logic              in_ready_o,
  output flp_pkg::flp_ctrl_t ctrl_o
);

  flp_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      flp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = flp_pkg::ST_EXEC;
        end
      end
      flp_pkg::ST_EXEC: begin
        if (out_free_i) begin
          state_d = flp_pkg::ST_IDLE;
        end
      end
      default: state_d = flp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    ctrl_o.accept = 1'b0;
    ctrl_o.fire   = 1'b0;
    case (state_q)
      flp_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = in_valid_i;
      end
      flp_pkg::ST_EXEC: begin
        ctrl_o.fire = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/free_list_slot_pool_core.sv
// Top level of the free-list slot pool: LIFO free list, per-slot in-use flag and value.
//
//  channel   | dir | handshake                    | contents
//  ----------+-----+------------------------------+------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: mode; tdata: index, value
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: ok, index, in_use, value, full
//
//  The accept issues the slot-table lookup; the write-back of the entry and the load of
//  the result follow in the EXEC state. The head pointer of the next item depends on
//  the looked-up next link, which the registered RAM read sets.
//  Reset: no clearing pass. A fill mark tracks how far allocation has reached since
//  the last clear; entries at or above it read as never touched (next link i+1, not
//  in use). Clear needs no clearing pass either.
//  Stalls: a held result keeps the item in its write-back cycle; input is taken
//  again as soon as the result register is loaded.
module free_list_slot_pool_core #(
  parameter int POOL_SIZE   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [flp_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // slot_index[6:0], item_value[38:7]
  input  logic [flp_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // mode[1:0]
  // result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [flp_pkg::M_TDATA_W-1:0]  m_axis_tdata   // ok[0], given_index[6:1],
                                                        // in_use[7], read_value[39:8],
                                                        // pool_full[40]
);

  localparam int AW  = $clog2(POOL_SIZE);        // slot address
  localparam int HW  = $clog2(POOL_SIZE + 1);    // pointer, POOL_SIZE is end of list
  localparam int IW  = flp_pkg::IDX_W;
  localparam int CW  = (HW > IW) ? HW : IW;      // index compare width
  localparam int EW  = 1 + HW + VALUE_WIDTH;     // {value, next, used}
  localparam int GW  = flp_pkg::GIDX_W;
  localparam int RVW = flp_pkg::RVAL_W;
  localparam int IVW = flp_pkg::IVAL_W;

  flp_pkg::flp_ctrl_t ctrl;
  logic               out_free;

  // captured item
  flp_pkg::mode_e     op_mode_q;
  logic [CW-1:0]      op_idx_q;
  logic [VALUE_WIDTH-1:0] op_val_q;

  // list state
  logic [HW-1:0]      head_q, head_d;
  logic [HW-1:0]      hwm_q, hwm_d;     // fill mark: entries at and above are untouched

  // slot table port signals
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [EW-1:0]      ram_wdata, ram_rdata;
  logic [CW-1:0]      in_idx;
  flp_pkg::mode_e     in_mode;

  // looked-up entry
  logic               ent_used;
  logic [HW-1:0]      ent_next;
  logic [VALUE_WIDTH-1:0] ent_val;
  logic               head_live, idx_live;

  // result
  logic               res_ok, res_used;
  logic [GW-1:0]      res_gidx;
  logic [RVW-1:0]     res_rval;
  logic               out_valid_q, out_valid_d;
  logic               out_ok_q, out_used_q, out_full_q;
  logic [GW-1:0]      out_gidx_q;
  logic [RVW-1:0]     out_rval_q;

  assign out_free = !out_valid_q || m_axis_tready;

  flp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  // lookup address: alloc reads the head slot, free and read the given slot
  assign in_mode   = flp_pkg::mode_e'(s_axis_tuser);
  assign in_idx    = CW'(s_axis_tdata[IW-1:0]);
  assign ram_raddr = (in_mode == flp_pkg::MODE_ALLOC) ? head_q[AW-1:0] : in_idx[AW-1:0];

  flp_ram #(
    .WIDTH (EW),
    .DEPTH (POOL_SIZE)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl.accept),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent_used  = ram_rdata[0];
  assign ent_next  = ram_rdata[HW:1];
  assign ent_val   = ram_rdata[EW-1:HW+1];
  assign head_live = head_q < hwm_q;
  assign idx_live  = op_idx_q < CW'(hwm_q);   // also implies in range

  // read-modify-write of the looked-up entry
  always_comb begin
    head_d    = head_q;
    hwm_d     = hwm_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    res_ok    = 1'b0;
    res_used  = 1'b0;
    res_gidx  = '0;
    res_rval  = '0;
    case (op_mode_q)
      flp_pkg::MODE_ALLOC: begin
        if (head_q != HW'(POOL_SIZE)) begin
          // an untouched head always sits at the fill mark
          head_d    = head_live ? ent_next : head_q + HW'(1);
          hwm_d     = head_live ? hwm_q : hwm_q + HW'(1);
          ram_we    = 1'b1;
          ram_waddr = head_q[AW-1:0];
          ram_wdata = {op_val_q, head_d, 1'b1};
          res_ok    = 1'b1;
          res_gidx  = GW'(head_q);
        end
      end
      flp_pkg::MODE_FREE: begin
        if (idx_live && ent_used) begin
          head_d    = HW'(op_idx_q);
          ram_we    = 1'b1;
          ram_waddr = op_idx_q[AW-1:0];
          ram_wdata = {ent_val, head_q, 1'b0};
          res_ok    = 1'b1;
        end
      end
      flp_pkg::MODE_CLEAR: begin
        head_d = '0;
        hwm_d  = '0;
        res_ok = 1'b1;
      end
      flp_pkg::MODE_READ: begin
        if (idx_live && ent_used) begin
          res_used = 1'b1;
          res_rval = RVW'(ent_val);
        end
      end
      default: ;
    endcase
    if (!ctrl.fire) begin
      head_d = head_q;
      hwm_d  = hwm_q;
      ram_we = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      hwm_q       <= '0;
      out_valid_q <= 1'b0;
      op_mode_q   <= flp_pkg::MODE_READ;
    end else begin
      head_q      <= head_d;
      hwm_q       <= hwm_d;
      out_valid_q <= out_valid_d;
      if (ctrl.accept) begin
        op_mode_q <= in_mode;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      op_idx_q <= in_idx;
      op_val_q <= VALUE_WIDTH'(s_axis_tdata[IW+IVW-1:IW]);
    end
    if (ctrl.fire) begin
      out_ok_q   <= res_ok;
      out_gidx_q <= res_gidx;
      out_used_q <= res_used;
      out_rval_q <= res_rval;
      out_full_q <= (head_d == HW'(POOL_SIZE));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_full_q, out_rval_q, out_used_q, out_gidx_q, out_ok_q};

endmodule

### sv/flp_chk.sv
// Port-level checker for the free-list slot pool, bound to the top level.
module flp_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [flp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic [flp_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [flp_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic res_ok, res_used;
  logic [flp_pkg::GIDX_W-1:0] res_gidx;
  logic [flp_pkg::RVAL_W-1:0] res_rval;

  assign res_ok   = m_axis_tdata[flp_pkg::OUT_OK_LSB];
  assign res_used = m_axis_tdata[flp_pkg::OUT_USED_LSB];
  assign res_gidx = m_axis_tdata[flp_pkg::OUT_GIDX_LSB +: flp_pkg::GIDX_W];
  assign res_rval = m_axis_tdata[flp_pkg::OUT_RVAL_LSB +: flp_pkg::RVAL_W];

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken during write-back");

  // a read result never reports ok, an alloc/free/clear never reports in_use
  a_ok_vs_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_ok && res_used))
    else $error("ok and in_use both set");

  // a nonzero index or value only comes with the flag that owns it
  a_fields_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_gidx == '0 || res_ok) && (res_rval == '0 || res_used))
    else $error("index or value without its flag");

endmodule

bind free_list_slot_pool_core flp_chk u_flp_chk (.*);
